>>> sv/paq_pkg.sv
// Package: shared types and constants for the periodic alarm queue.
`timescale 1ns / 1ps
package paq_pkg;
   localparam int SLOTS = 16;
   localparam int ID_W = 4;
   localparam int MAX_FIRES = 63;
   localparam int FIRE_W = 6;
   localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_CREATE = 2'd1,
      KIND_MODIFY = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   // one beat of the search chain: best candidate so far
   typedef struct packed {
      logic             found;
      logic [ID_W-1:0]  id;
      logic [63:0]      expiry;
   } cand_type;

   // command from controller to every slot cell
   typedef struct packed {
      logic             wr;       // write slot fields
      logic             arm_wr;   // write expiry and armed
      logic             disarm;   // clear armed
      logic             fire;     // fire the addressed slot
      logic [ID_W-1:0]  id;
      logic [63:0]      expiry;
      logic [31:0]      period;
      logic             periodic;
      logic             notify;
      logic [31:0]      tag;
   } cmd_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ALL64 : s[63:0];
   endfunction
endpackage

>>> sv/paq_cell.sv
// Slot cell: holds one alarm and passes the earliest candidate along the chain.
`timescale 1ns / 1ps
module paq_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic [paq_pkg::ID_W-1:0] my_id,
   input  paq_pkg::cmd_type  cmd,
   input  paq_pkg::cand_type cand_prev,
   output paq_pkg::cand_type cand_out,
   output logic [63:0]       expiry,
   output logic              notify,
   output logic [31:0]       tag
);
   import paq_pkg::*;

   logic        armed_ff;
   logic [63:0] expiry_ff;
   logic [31:0] period_ff;
   logic        periodic_ff;
   logic        notify_ff;
   logic [31:0] tag_ff;
   cand_type    cand_ff;
   cand_type    cand_in;
   logic        hit;

   assign hit      = (cmd.id == my_id);
   assign expiry   = expiry_ff;
   assign notify   = notify_ff;
   assign tag      = tag_ff;
   assign cand_out = cand_ff;

   // keep earlier candidate on a tie, so lower slot wins
   always_comb begin
      cand_in = cand_prev;
      if (armed_ff && (!cand_prev.found || expiry_ff < cand_prev.expiry)) begin
         cand_in.found  = 1'b1;
         cand_in.id     = my_id;
         cand_in.expiry = expiry_ff;
      end
   end

   // hand the candidate to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   // update slot on controller commands
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else if (hit) begin
         if (cmd.arm_wr) begin
            armed_ff <= (cmd.expiry != 64'd0);
         end else if (cmd.disarm) begin
            armed_ff <= 1'b0;
         end else if (cmd.fire && !periodic_ff) begin
            armed_ff <= 1'b0;
         end
      end
      if (hit) begin
         if (cmd.wr) begin
            period_ff   <= cmd.period;
            periodic_ff <= cmd.periodic;
            notify_ff   <= cmd.notify;
            tag_ff      <= cmd.tag;
         end
         if (cmd.arm_wr) begin
            expiry_ff <= cmd.expiry;
         end else if (cmd.fire && periodic_ff) begin
            expiry_ff <= sat_add(expiry_ff, {32'd0, period_ff});
         end
      end
   end
endmodule

>>> sv/periodic_alarm_queue.sv
// Top level: alarm controller over a registered chain of sixteen slot cells.
// Each request passes the candidate through the registered cell chain, then a decide state;
// while the earliest armed alarm is due (within early_margin) and under 63 firings it fires
// and the search repeats; a modify that keeps the expiry skips straight to the final beat.
// Requests are taken one at a time; a stalled result beat holds the sequence.
// Reset: synchronous; clears all armed bits and early_margin; other slot fields undefined.
`timescale 1ns / 1ps
module periodic_alarm_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_now,
   input  logic [3:0]  req_alarm_id,
   input  logic [63:0] req_expire_time,
   input  logic [31:0] req_period,
   input  logic        req_periodic,
   input  logic        req_notify,
   input  logic [31:0] req_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fire_valid,
   output logic [3:0]  rsp_fired_id,
   output logic [31:0] rsp_fired_tag,
   output logic        rsp_next_valid,
   output logic [63:0] rsp_next_delay,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_early_margin
);
   import paq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_DECIDE, ST_FINAL, ST_OUT
   } state_type;

   state_type        state_ff;
   logic [31:0]      margin_ff;
   logic [63:0]      now_ff;
   logic [63:0]      limit_ff;
   logic             scan_ff;
   logic [FIRE_W-1:0] fires_ff;
   logic [ID_W-1:0]  wait_ff;
   logic             rsp_valid_ff;
   logic             rsp_fire_valid_ff;
   logic [3:0]       rsp_fired_id_ff;
   logic [31:0]      rsp_fired_tag_ff;
   logic             rsp_next_valid_ff;
   logic [63:0]      rsp_next_delay_ff;
   logic             rsp_last_ff;
   cand_type         best;
   cmd_type          cmd;
   cand_type         chain [SLOTS+1];
   logic [63:0]      c_exp  [SLOTS];
   logic             c_not  [SLOTS];
   logic [31:0]      c_tag  [SLOTS];
   logic             acc;
   logic             out_free;
   logic             fire_now;
   logic             load_rsp;

   assign chain[0]  = '0;
   assign best      = chain[SLOTS];
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign acc       = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire_now  = (state_ff == ST_DECIDE) && best.found &&
                      (best.expiry <= limit_ff) && (fires_ff != FIRE_W'(MAX_FIRES));
   assign load_rsp  = out_free && ((fire_now && c_not[best.id]) || (state_ff == ST_FINAL));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fire_valid = rsp_fire_valid_ff;
   assign rsp_fired_id   = rsp_fired_id_ff;
   assign rsp_fired_tag  = rsp_fired_tag_ff;
   assign rsp_next_valid = rsp_next_valid_ff;
   assign rsp_next_delay = rsp_next_delay_ff;
   assign rsp_last       = rsp_last_ff;

   // build the cell command from the accepted request or a firing
   always_comb begin
      cmd          = '0;
      cmd.period   = req_period;
      cmd.periodic = req_periodic;
      cmd.notify   = req_notify;
      cmd.tag      = req_tag;
      cmd.expiry   = req_expire_time;
      cmd.id       = req_alarm_id;
      if (acc) begin
         unique case (kind_type'(req_kind))
            KIND_CREATE: begin
               cmd.wr     = 1'b1;
               cmd.arm_wr = 1'b1;
            end
            KIND_MODIFY: begin
               cmd.wr     = 1'b1;
               cmd.arm_wr = (c_exp[req_alarm_id] != req_expire_time);
            end
            KIND_REMOVE: cmd.disarm = 1'b1;
            default: ;
         endcase
      end else if (fire_now && out_free) begin
         cmd.fire = 1'b1;
         cmd.id   = best.id;
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      paq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_id     (ID_W'(g)),
         .cmd       (cmd),
         .cand_prev (chain[g]),
         .cand_out  (chain[g+1]),
         .expiry    (c_exp[g]),
         .notify    (c_not[g]),
         .tag       (c_tag[g])
      );
   end

   // sequence the request: search, fire, repeat, then report
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         margin_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            margin_ff <= csr_early_margin;
         end
         // hold the result beat until taken, load a new one when free
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  now_ff   <= req_now;
                  limit_ff <= sat_add(req_now, {32'd0, margin_ff});
                  fires_ff <= '0;
                  wait_ff  <= '0;
                  scan_ff  <= !((kind_type'(req_kind) == KIND_MODIFY) &&
                              (c_exp[req_alarm_id] == req_expire_time));
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               // wait until the candidate has crossed every cell
               if (wait_ff == ID_W'(SLOTS - 1)) begin
                  state_ff <= scan_ff ? ST_DECIDE : ST_FINAL;
               end else begin
                  wait_ff <= wait_ff + 1'b1;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  if (fire_now) begin
                     fires_ff <= fires_ff + 1'b1;
                     if (c_not[best.id]) begin
                        rsp_fire_valid_ff <= 1'b1;
                        rsp_fired_id_ff   <= best.id;
                        rsp_fired_tag_ff  <= c_tag[best.id];
                        rsp_next_valid_ff <= 1'b0;
                        rsp_next_delay_ff <= 64'd0;
                        rsp_last_ff       <= 1'b0;
                     end
                     wait_ff  <= '0;
                     state_ff <= ST_SEARCH;
                  end else begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               // chain now reflects final state; wait for free output slot
               if (out_free) begin
                  rsp_fire_valid_ff <= 1'b0;
                  rsp_fired_id_ff   <= '0;
                  rsp_fired_tag_ff  <= '0;
                  rsp_next_valid_ff <= best.found;
                  rsp_next_delay_ff <= (best.found && best.expiry > now_ff) ?
                                       best.expiry - now_ff : 64'd0;
                  rsp_last_ff       <= 1'b1;
                  state_ff          <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_valid_ff && rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
